>>> hdl/mtfr_pkg.sv
// Package for the move-to-front rank encoder.
// Holds field widths, limits and the request token that travels down the cell row.
// No dependencies.
package mtfr_pkg;

    localparam int ID_W      = 11;             // item identifier and count width
    localparam int OUT_RANK_W = 10;            // width of items_above
    localparam logic [OUT_RANK_W-1:0] RANK_MAX = 10'd1023;
    localparam logic [ID_W-1:0] COUNT_RESET = 11'd1024;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Request travelling from cell to cell; the rank travels beside it
    typedef struct packed {
        logic            valid;   // a request occupies this slot
        logic            bad;     // identifier out of range: pass untouched
        logic            found;   // identifier already met above this cell
        logic            last;    // restore the initial order behind this request
        logic [ID_W-1:0] id;      // requested identifier
        logic [ID_W-1:0] carry;   // entry displaced from the cell above
    } mtfr_token_t;

endpackage

>>> hdl/mtfr_cell.sv
// One stack entry of the move-to-front rank encoder and its token slot.
// Depends on mtfr_pkg.
module mtfr_cell #(
    parameter int K      = 0,
    parameter int RANK_W = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 restore,
    input  mtfr_pkg::mtfr_token_t tok_i,
    input  logic [RANK_W-1:0]    rank_i,
    output mtfr_pkg::mtfr_token_t tok_o,
    output logic [RANK_W-1:0]    rank_o
);

    localparam logic [mtfr_pkg::ID_W-1:0] INIT = mtfr_pkg::ID_W'(K + 1);
    localparam logic [RANK_W-1:0]         POS  = RANK_W'(K);

    logic [mtfr_pkg::ID_W-1:0] val_reg, val_next;
    mtfr_pkg::mtfr_token_t     tok_reg, tok_next;
    logic [RANK_W-1:0]         rank_reg, rank_next;
    logic                      active;
    logic                      hit;

    assign active = tok_i.valid && !tok_i.bad && !tok_i.found;
    assign hit    = active && (val_reg == tok_i.id);

    always_comb begin
        tok_next  = tok_i;
        rank_next = rank_i;
        val_next  = val_reg;
        if (active) begin
            // swap: take the carried entry, hand the held one on
            val_next       = tok_i.carry;
            tok_next.carry = val_reg;
            if (hit) begin
                tok_next.found = 1'b1;
                rank_next      = POS;
            end
        end
        if (tok_i.valid && tok_i.last) begin
            val_next = INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg       <= INIT;
            tok_reg.valid <= 1'b0;
        end else begin
            if (restore) begin
                val_reg <= INIT;
            end else if (en) begin
                val_reg <= val_next;
            end
            if (en) begin
                tok_reg.valid <= tok_next.valid;
            end
        end
        if (en) begin
            tok_reg.bad   <= tok_next.bad;
            tok_reg.found <= tok_next.found;
            tok_reg.last  <= tok_next.last;
            tok_reg.id    <= tok_next.id;
            tok_reg.carry <= tok_next.carry;
            rank_reg      <= rank_next;
        end
    end

    assign tok_o  = tok_reg;
    assign rank_o = rank_reg;

endmodule

>>> hdl/move_to_front_rank_encoder.sv
// Top level of the move-to-front rank encoder: input check, row of stack cells,
// result formatting. Depends on mtfr_pkg and mtfr_cell.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  s_       | s_tvalid / s_tready    | tdata[10:0] item_id, tlast last_in_case
//  m_       | m_tvalid / m_tready    | tdata[9:0] items_above, tuser bad_item
//  cfg_     | cfg_valid / cfg_ready  | cfg_data[10:0] item_count
//
// Each request walks the row of MAX_ITEMS cells, one cell per cycle while the row is
// not frozen, swapping entries on its way; its result is presented on m_ by the
// register of the last cell. One transaction per cycle is taken while the row advances.
// Reset and every item_count write restore the ascending order;
// s_tready drops while cfg_valid is high.
// A result held on m_ with m_tready low freezes the whole row and s_tready.
module move_to_front_rank_encoder #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mtfr_pkg::S_TDATA_W-1:0]    s_tdata,   // [10:0] item_id
    input  logic                              s_tlast,   // last_in_case
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mtfr_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] items_above
    output logic                              m_tuser,   // bad_item
    // item_count register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mtfr_pkg::ID_W-1:0]         cfg_data
);

    localparam int RANK_W = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
    localparam int EXT_W  = (RANK_W > mtfr_pkg::OUT_RANK_W) ? RANK_W : mtfr_pkg::OUT_RANK_W;

    logic [mtfr_pkg::ID_W-1:0] count_reg;
    logic                      en;
    logic                      restore;
    logic [mtfr_pkg::ID_W-1:0] in_id;
    logic                      in_bad;
    mtfr_pkg::mtfr_token_t     entry_tok;

    mtfr_pkg::mtfr_token_t     tok   [MAX_ITEMS+1];
    logic [RANK_W-1:0]         rank  [MAX_ITEMS+1];

    logic [EXT_W-1:0]          rank_ext;
    logic [mtfr_pkg::OUT_RANK_W-1:0] rank_out;

    // Hold the whole row while the result slot is full and not taken
    assign en        = !tok[MAX_ITEMS].valid || m_tready;
    // Refuse requests during a register write so none slips past the restore
    assign s_tready  = en && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign restore   = cfg_valid && cfg_ready;

    // Register write: count takes effect and order restores at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= mtfr_pkg::COUNT_RESET;
        end else if (restore) begin
            count_reg <= cfg_data;
        end
    end

    // Range check at entry; effective count is item_count limited to MAX_ITEMS
    assign in_id  = s_tdata[mtfr_pkg::ID_W-1:0];
    assign in_bad = (in_id == '0) || (in_id > count_reg) || (32'(in_id) > 32'(MAX_ITEMS));

    always_comb begin
        entry_tok.valid = s_tvalid && s_tready;
        entry_tok.bad   = in_bad;
        entry_tok.found = 1'b0;
        entry_tok.last  = s_tlast;
        entry_tok.id    = in_id;
        entry_tok.carry = in_id;
    end

    assign tok[0]  = entry_tok;
    assign rank[0] = '0;

    // Row of stack entries; cell 0 is the top of the stack
    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        mtfr_cell #(
            .K      (k),
            .RANK_W (RANK_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .restore (restore),
            .tok_i   (tok[k]),
            .rank_i  (rank[k]),
            .tok_o   (tok[k+1]),
            .rank_o  (rank[k+1])
        );
    end

    // Saturate the rank to the result width; drop it for a bad request
    assign rank_ext = EXT_W'(rank[MAX_ITEMS]);
    always_comb begin
        if (tok[MAX_ITEMS].bad) begin
            rank_out = '0;
        end else if (rank_ext > EXT_W'(mtfr_pkg::RANK_MAX)) begin
            rank_out = mtfr_pkg::RANK_MAX;
        end else begin
            rank_out = rank_ext[mtfr_pkg::OUT_RANK_W-1:0];
        end
    end

    assign m_tvalid = tok[MAX_ITEMS].valid;
    assign m_tdata  = {{(mtfr_pkg::M_TDATA_W - mtfr_pkg::OUT_RANK_W){1'b0}}, rank_out};
    assign m_tuser  = tok[MAX_ITEMS].bad;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for move_to_front_rank_encoder: directed and random request streams,
// in-bench move-to-front predictor, in-order result comparison.
// Depends on mtfr_pkg and the encoder RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_ITEMS     = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MISMATCH_SHOW = 10;

    typedef enum {
        IDLE_RECV_HEAVY,   // sender idles 11 %, receiver 46 %
        IDLE_SEND_HEAVY,   // sender idles 46 %, receiver 11 %
        IDLE_NONE          // both sides always ready
    } idle_mode_t;

    typedef struct packed {
        logic [mtfr_pkg::ID_W-1:0] id;
        logic                      last;
    } mtf_request_t;

    typedef struct packed {
        logic [mtfr_pkg::OUT_RANK_W-1:0] rank;
        logic                            bad;
    } mtf_rank_t;

    // DUT ports
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mtfr_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // [10:0] item_id
    logic                            s_tlast   = 1'b0; // last_in_case
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mtfr_pkg::M_TDATA_W-1:0]  m_tdata;          // [9:0] items_above
    logic                            m_tuser;          // bad_item
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mtfr_pkg::ID_W-1:0]       cfg_data  = '0;

    // Predictor state: entry 0 is the top of the stack
    logic [mtfr_pkg::ID_W-1:0]       mtf_stack [MAX_ITEMS];
    logic [mtfr_pkg::ID_W-1:0]       mtf_count = mtfr_pkg::COUNT_RESET;

    // Stimulus and scoreboard
    mtf_request_t          request_queue[$];
    mtf_rank_t             pending_ranks[$];
    mtf_request_t          next_request;
    mtf_rank_t             want_rank;
    bit                    s_took         = 1'b0;
    int                    send_idle_pct  = 0;
    int                    recv_idle_pct  = 0;
    int                    requests_queued = 0;
    int                    results_checked = 0;
    int                    mismatches     = 0;
    int                    cycle_count    = 0;
    int                    config_writes  = 0;
    int                    bad_predicted  = 0;
    int                    restores_seen  = 0;

    move_to_front_rank_encoder #(
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Put the stack back to ascending order, item 1 on top
    function automatic void restore_stack();
        for (int k = 0; k < MAX_ITEMS; k++) begin
            mtf_stack[k] = mtfr_pkg::ID_W'(k + 1);
        end
    endfunction

    // Effective number of items: the register value, saturated at MAX_ITEMS
    function automatic int live_items();
        return (mtf_count > MAX_ITEMS) ? MAX_ITEMS : int'(mtf_count);
    endfunction

    // Work out the rank of one request, then promote the item to the top
    function automatic mtf_rank_t predict_rank(mtf_request_t req);
        int        n;
        int        hit;
        mtf_rank_t res;
        n        = live_items();
        hit      = -1;
        res.rank = '0;
        res.bad  = 1'b1;
        if (req.id != 0 && req.id <= n) begin
            for (int p = 0; p < n; p++) begin
                if (mtf_stack[p] == req.id) begin
                    hit = p;
                    break;
                end
            end
        end
        if (hit >= 0) begin
            res.bad  = 1'b0;
            res.rank = (hit > mtfr_pkg::RANK_MAX) ? mtfr_pkg::RANK_MAX
                                                  : mtfr_pkg::OUT_RANK_W'(hit);
            for (int p = hit; p > 0; p--) begin
                mtf_stack[p] = mtf_stack[p - 1];
            end
            mtf_stack[0] = req.id;
        end else begin
            bad_predicted++;
        end
        // End of case: the order comes back once this result is formed
        if (req.last) begin
            restore_stack();
            restores_seen++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            // Previous transaction gone (or none held): offer the next one or idle
            s_took = 1'b0;
            if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_request = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= mtfr_pkg::S_TDATA_W'(next_request.id);
                s_tlast  <= next_request.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // Receiver back-pressure, drawn afresh every cycle
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, predict on acceptance, check in order
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_checked, requests_queued);
            $display("FAILURE");
            $finish;
        end else if (aresetn) begin
            // Accepted request: advance the predictor and hold the expected rank
            if (s_tvalid && s_tready) begin
                pending_ranks.push_back(
                    predict_rank({s_tdata[mtfr_pkg::ID_W-1:0], s_tlast}));
                s_took = 1'b1;
            end
            // Accepted result: compare against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (pending_ranks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOW)
                        $display("unexpected result: items_above %0d bad_item %0b",
                                 m_tdata[mtfr_pkg::OUT_RANK_W-1:0], m_tuser);
                end else begin
                    want_rank = pending_ranks.pop_front();
                    results_checked++;
                    // Padding above items_above must read as zero too
                    if (m_tdata !== mtfr_pkg::M_TDATA_W'(want_rank.rank)
                            || m_tuser !== want_rank.bad) begin
                        mismatches++;
                        if (mismatches <= MISMATCH_SHOW)
                            $display({"result %0d: want items_above %0d bad_item %0b,",
                                      " got tdata %0d bad_item %0b"},
                                     results_checked, want_rank.rank, want_rank.bad,
                                     m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_request(logic [mtfr_pkg::ID_W-1:0] id, logic last);
        request_queue.push_back('{id: id, last: last});
        requests_queued++;
    endfunction

    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_RECV_HEAVY: begin
                send_idle_pct = 11;
                recv_idle_pct = 46;
            end
            IDLE_SEND_HEAVY: begin
                send_idle_pct = 46;
                recv_idle_pct = 11;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    // Hold until every queued request has come back as a result
    task automatic wait_drained();
        while (results_checked != requests_queued) @(posedge aclk);
    endtask

    // Write item_count while the block is idle; the predictor restores with it
    task automatic write_item_count(input logic [mtfr_pkg::ID_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        mtf_count = value;
        restore_stack();
        config_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random requests: recently used items (short ranks, deep reordering), uniform picks,
    // the stack extremes and out-of-range identifiers
    task automatic queue_random(input int total, input bit pause_midway);
        int                        n;
        int                        pick;
        logic [mtfr_pkg::ID_W-1:0] id;
        logic [mtfr_pkg::ID_W-1:0] recent [8];
        n = live_items();
        for (int i = 0; i < 8; i++) recent[i] = mtfr_pkg::ID_W'((i % n) + 1);
        for (int k = 0; k < total; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                if (n < MAX_ITEMS && $urandom_range(1) == 1)
                    id = mtfr_pkg::ID_W'($urandom_range(MAX_ITEMS, n + 1));
                else
                    id = '0;
            end else if (pick < 12) begin
                id = ($urandom_range(1) == 1) ? mtfr_pkg::ID_W'(n) : mtfr_pkg::ID_W'(1);
            end else if (pick < 55) begin
                id = recent[$urandom_range(7)];
            end else begin
                id = mtfr_pkg::ID_W'($urandom_range(n, 1));
            end
            if (id != 0 && id <= n) recent[$urandom_range(7)] = id;
            queue_request(id, $urandom_range(15) == 0);
            // Starve the input until the pipeline has emptied completely
            if (pause_midway && k == total / 2) wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        restore_stack();
        set_idle(IDLE_RECV_HEAVY);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full stack from reset: both ends, repeats, out-of-range, restores
        queue_request(11'd1, 1'b0);
        queue_request(11'd1024, 1'b0);
        queue_request(11'd1024, 1'b0);
        queue_request(11'd1, 1'b0);
        queue_request(11'd2, 1'b0);
        queue_request(11'd0, 1'b0);
        queue_request(11'd512, 1'b1);
        queue_request(11'd1024, 1'b0);
        queue_request(11'd0, 1'b1);
        queue_request(11'd1, 1'b0);

        // Single item: every valid request ranks zero
        write_item_count(11'd1);
        queue_request(11'd1, 1'b0);
        queue_request(11'd2, 1'b0);
        queue_request(11'd1, 1'b1);
        queue_request(11'd0, 1'b0);

        // Zero count: nothing is valid
        write_item_count(11'd0);
        queue_request(11'd1, 1'b0);
        queue_request(11'd0, 1'b1);
        queue_request(11'd1024, 1'b0);

        // Count above the row size saturates at MAX_ITEMS
        write_item_count(11'd2047);
        queue_request(11'd1024, 1'b0);
        queue_request(11'd1024, 1'b0);
        queue_request(11'd1023, 1'b1);

        // Two items
        write_item_count(11'd2);
        queue_request(11'd2, 1'b0);
        queue_request(11'd2, 1'b0);
        queue_request(11'd1, 1'b0);
        queue_request(11'd3, 1'b0);

        // Random phases: receiver-heavy idling first
        write_item_count(11'd6);
        queue_random(350, 1'b1);
        write_item_count(11'd1024);
        queue_random(200, 1'b0);

        // Sender-heavy idling
        wait_drained();
        set_idle(IDLE_SEND_HEAVY);
        write_item_count(11'd37);
        queue_random(350, 1'b0);
        write_item_count(11'd1);
        queue_random(60, 1'b0);

        // No idling at all
        wait_drained();
        set_idle(IDLE_NONE);
        write_item_count(11'd300);
        queue_random(300, 1'b0);
        write_item_count(mtfr_pkg::ID_W'($urandom_range(1024, 2)));
        queue_random(240, 1'b0);

        // Let any stray results surface before the summary
        wait_drained();
        repeat (MAX_ITEMS + 32) @(posedge aclk);

        $display("covered %0d requests across %0d item_count writes:",
                 requests_queued, config_writes);
        $display("  %0d out-of-range ids, %0d case restores, %0d results checked",
                 bad_predicted, restores_seen, results_checked);
        if (mismatches == 0 && pending_ranks.size() == 0
                && results_checked == requests_queued) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d expectations left",
                     mismatches, pending_ranks.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mtfr_pkg.sv
hdl/mtfr_cell.sv
hdl/move_to_front_rank_encoder.sv
dv/testbench.sv
